FILE: design/assert_macros.svh
// Assertion macros shared by the snapshot store RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ZZ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("zzcs: check failed");
`define ZZ_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("zzcs: check failed");
`else
`define ZZ_ASSERT(lbl, clk, rst, prop)
`define ZZ_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: design/zzcs_pkg.sv
// Types and constants for the dual-copy snapshot store.
// No dependencies; imported by zzcs_ctrl, zzcs_dp and the top level.
`default_nettype none

package zzcs_pkg;

  localparam int OP_W      = 2;
  localparam int PAGE_W    = 10;
  localparam int DATA_W    = 64;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 72;
  localparam int M_PAD_W   = M_TDATA_W - DATA_W - 1;
  localparam int PEXT_W    = 17;

  localparam logic [7:0]        FILL_BYTE = 8'h53;
  localparam logic [DATA_W-1:0] FILL_WORD = {8{FILL_BYTE}};

  typedef enum logic [OP_W-1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_PREPARE  = 2'd2,
    OP_SNAPSHOT = 2'd3
  } op_e_t;

  // per-page select bits
  typedef struct packed {
    logic ws;
    logic rs;
  } sel_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic sweep;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_prepare;
    logic clear_done;
    logic sweep_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/zzcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module zzcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/zzcs_ctrl.sv
// Controller state machine of the snapshot store: clear pass, lookup,
// prepare sweep and result hand-off. Depends on zzcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module zzcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire zzcs_pkg::dp_stat_t stat,
  output zzcs_pkg::ctl_cmd_t      cmd
);

  import zzcs_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = stat.is_prepare ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  `ZZ_ASSERT(a_take_to_lookup, clk, rst, cmd.take |=> (state == ST_LOOKUP))
  `ZZ_ASSERT(a_commit_free, clk, rst, cmd.commit |-> stat.out_free)
  `ZZ_ASSERT(a_sweep_holds, clk, rst, (cmd.sweep && !stat.sweep_done) |=> cmd.sweep)

endmodule

`default_nettype wire

FILE: design/zzcs_dp.sv
// Datapath of the snapshot store: item registers, sweep counter, select and
// copy memories, result logic and output register. Depends on zzcs_pkg, zzcs_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module zzcs_dp #(
  parameter int NUM_PAGES = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire zzcs_pkg::ctl_cmd_t                  cmd,
  output zzcs_pkg::dp_stat_t                       stat,
  input  wire logic [zzcs_pkg::S_TDATA_W-1:0]      s_tdata,
  input  wire logic [zzcs_pkg::OP_W-1:0]           s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [zzcs_pkg::M_TDATA_W-1:0]      m_tdata
);

  import zzcs_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);
  localparam int CW = AW + 1;

  op_e_t                op_q;
  logic [AW-1:0]        page_addr_q;
  logic                 page_ok_q;
  logic [WORD_BITS-1:0] data_q;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_dec;
  logic [PEXT_W-1:0]    page_ext;

  logic [1:0]           sel_rdata;
  sel_t                 sel_rd;
  sel_t                 sel_wdata;
  logic                 sel_we;
  logic [AW-1:0]        sel_waddr;
  logic [AW-1:0]        sel_raddr;

  logic [WORD_BITS-1:0] c0_rdata;
  logic [WORD_BITS-1:0] c1_rdata;
  logic                 c0_we;
  logic                 c1_we;
  logic [AW-1:0]        c0_waddr;
  logic [WORD_BITS-1:0] c0_wdata;

  logic                 res_used;
  logic [WORD_BITS-1:0] res_word;
  logic                 wr_hit;

  assign page_ext = PEXT_W'(s_tdata[PAGE_W-1:0]);
  assign cnt_dec  = cnt - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q        <= op_e_t'(s_tuser);
      page_addr_q <= page_ext[AW-1:0];
      page_ok_q   <= page_ext < PEXT_W'(NUM_PAGES);
      data_q      <= s_tdata[PAGE_W +: WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.take) begin
      cnt <= '0;
    end else if (cmd.clear || cmd.sweep) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign stat.is_prepare = (op_q == OP_PREPARE);
  assign stat.clear_done = (cnt == CW'(NUM_PAGES - 1));
  assign stat.sweep_done = (cnt == CW'(NUM_PAGES));
  assign stat.out_free   = !m_tvalid || m_tready;

  assign sel_rd = sel_t'(sel_rdata);

  always_comb begin
    res_used = 1'b0;
    res_word = '0;
    wr_hit   = 1'b0;
    if (page_ok_q) begin
      case (op_q)
        OP_READ: begin
          res_used = sel_rd.rs;
          res_word = sel_rd.rs ? c1_rdata : c0_rdata;
        end
        OP_WRITE: begin
          res_used = sel_rd.ws;
          wr_hit   = 1'b1;
        end
        OP_SNAPSHOT: begin
          // frozen copy is the one the write bit does not name
          res_used = !sel_rd.ws;
          res_word = sel_rd.ws ? c0_rdata : c1_rdata;
        end
        OP_PREPARE: begin
          res_used = 1'b0;
        end
        default: begin
          res_used = 1'b0;
        end
      endcase
    end
  end

  // sweep reads page cnt and writes back page cnt-1 from the registered read
  assign sel_raddr = cmd.sweep ? cnt[AW-1:0] : page_addr_q;
  assign sel_we    = cmd.clear || (cmd.sweep && (cnt != '0)) || (cmd.commit && wr_hit);

  always_comb begin
    if (cmd.clear) begin
      sel_waddr    = cnt[AW-1:0];
      sel_wdata.ws = 1'b1;
      sel_wdata.rs = 1'b0;
    end else if (cmd.sweep) begin
      sel_waddr    = cnt_dec[AW-1:0];
      sel_wdata.ws = !sel_rd.rs;
      sel_wdata.rs = sel_rd.rs;
    end else begin
      sel_waddr    = page_addr_q;
      sel_wdata.ws = sel_rd.ws;
      sel_wdata.rs = sel_rd.ws;
    end
  end

  assign c0_we    = cmd.clear || (cmd.commit && wr_hit && !sel_rd.ws);
  assign c0_waddr = cmd.clear ? cnt[AW-1:0] : page_addr_q;
  assign c0_wdata = cmd.clear ? FILL_WORD[WORD_BITS-1:0] : data_q;
  assign c1_we    = cmd.commit && wr_hit && sel_rd.ws;

  zzcs_ram #(.WIDTH(2), .DEPTH(NUM_PAGES)) u_sel_ram (
    .clk   (clk),
    .we    (sel_we),
    .waddr (sel_waddr),
    .wdata (sel_wdata),
    .raddr (sel_raddr),
    .rdata (sel_rdata)
  );

  zzcs_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_PAGES)) u_copy0_ram (
    .clk   (clk),
    .we    (c0_we),
    .waddr (c0_waddr),
    .wdata (c0_wdata),
    .raddr (page_addr_q),
    .rdata (c0_rdata)
  );

  zzcs_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_PAGES)) u_copy1_ram (
    .clk   (clk),
    .we    (c1_we),
    .waddr (page_addr_q),
    .wdata (data_q),
    .raddr (page_addr_q),
    .rdata (c1_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {M_PAD_W'(0), res_used, DATA_W'(res_word)};
    end
  end

  `ZZ_ASSERT(a_commit_shows, clk, rst, cmd.commit |=> m_tvalid)
  `ZZ_ASSERT(a_one_copy_write, clk, rst, !(c0_we && c1_we))
  `ZZ_ASSERT(a_out_holds, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)

endmodule

`default_nettype wire

FILE: design/zigzag_dual_copy_snapshot_store_top.sv
// Dual-copy snapshot page store, top level.
// Input word (s_*): s_tuser = operation (read, write, checkpoint prepare,
// snapshot read); s_tdata = page_index, write_data. Output word (m_*):
// m_tdata = read_data, copy_used. One output word per input word, in order.
// Read, write and snapshot read go from the accept in IDLE through LOOKUP,
// which issues the memory read, to FINISH, which uses the registered read data
// and commits; the result shows in m_tvalid right after the commit edge, and
// the next word is accepted back in IDLE. Checkpoint prepare adds a SWEEP state
// that walks the select memory one page per cycle through its single write port.
// After reset a clearing pass over every page loads the select bits and
// fills copy 0 with 0x53 bytes; s_tready stays low until it is done.
// A stalled receiver holds the result in the output register; one more input
// word is accepted and worked up to its result, then s_tready stays low
// until m_tready drains the register.
// Pages at or above NUM_PAGES answer zero and are never written.
// Depends on zzcs_pkg, zzcs_ctrl, zzcs_dp, zzcs_ram.
`default_nettype none

module zigzag_dual_copy_snapshot_store_top #(
  parameter int NUM_PAGES = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [9:0] page_index, [73:10] write_data, [79:74] zero
  input  wire logic [zzcs_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] operation
  input  wire logic [zzcs_pkg::OP_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [63:0] read_data, [64] copy_used, [71:65] zero
  output logic      [zzcs_pkg::M_TDATA_W-1:0] m_tdata
);

  import zzcs_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  zzcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  zzcs_dp #(.NUM_PAGES(NUM_PAGES), .WORD_BITS(WORD_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
